/* src/dome_strip_index_generator_unit_macros.svh */
// Assertion macros for the dome strip index generator.
// Each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef DOME_STRIP_INDEX_GENERATOR_UNIT_MACROS_SVH
`define DOME_STRIP_INDEX_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DSIG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dome strip index generator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dome strip index generator: next-cycle check failed");

`else

`define DSIG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DSIG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/dsig_pkg.sv */
`timescale 1ns / 1ps

package dsig_pkg;

    // Default widths of the index arithmetic and of the ring and stack counters.
    localparam int INDEX_BITS_DEFAULT = 16;
    localparam int COUNT_BITS_DEFAULT = 10;

    // Stream and configuration port widths.
    localparam int IN_DATA_BITS   = 8;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLICE_COUNT     = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STACK_COUNT     = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE_WINDING = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RESTART_VALUE   = 8'd3;

    // Reset values of the configuration registers.
    localparam int SLICE_COUNT_RESET   = 8;
    localparam int STACK_COUNT_RESET   = 8;
    localparam logic [CFG_DATA_BITS-1:0] RESTART_VALUE_RESET = 16'hFFFF;

endpackage

/* src/dome_strip_index_generator_unit.sv */
`timescale 1ns / 1ps
`include "dome_strip_index_generator_unit_macros.svh"

// Dome strip index generator. Every request on the input stream yields one
// entry of the index list of a dome drawn as triangle strips: a fan of pairs
// around apex vertex 0 first, then one strip per ring pair, each strip closed
// by a repeat of its first pair and a primitive-restart entry (flagged on
// o_m_tuser). The final entry of the whole list is flagged on o_m_tlast, after
// which the list starts over; bit 0 of the input data (rewind) restarts the
// list before the entry of that request is produced. The block takes one
// request per clock while the skid register is empty and delivers one index
// per clock while the output is not stalled. The strip, slice and ring
// counters are updated by combinational logic, each index is registered,
// and an output register plus a skid register keep the input ready while a
// finished index waits on a stalled output. Configuration writes (slice
// count, stack count, reverse winding, restart value) are always accepted
// and must be issued only while the block is idle; the counters read them live.
module dome_strip_index_generator_unit #(
    parameter int INDEX_BITS = dsig_pkg::INDEX_BITS_DEFAULT,
    parameter int COUNT_BITS = dsig_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream. i_s_tdata fields from bit 0: rewind (1), zero fill (7).
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [dsig_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    // Output stream. o_m_tdata fields from bit 0: vertex_index (INDEX_BITS),
    // zero fill to whole bytes. o_m_tuser fields from bit 0: is_restart (1).
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [((INDEX_BITS+7)/8)*8-1:0]     o_m_tdata,
    output logic                                o_m_tuser,
    output logic                                o_m_tlast,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dsig_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [dsig_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int OUT_DATA_BITS = ((INDEX_BITS + 7) / 8) * 8;
    localparam int POS_BITS      = COUNT_BITS + 1;
    // Index sums are formed at the wider of the two widths, then wrapped.
    localparam int SUM_BITS      = (INDEX_BITS > COUNT_BITS) ? INDEX_BITS : COUNT_BITS;

    // Configuration registers.
    logic [COUNT_BITS-1:0] r_slice_count;
    logic [COUNT_BITS-1:0] r_stack_count;
    logic                  r_reverse;
    logic [INDEX_BITS-1:0] r_restart_value;

    // Sequence state.
    logic [COUNT_BITS-1:0] r_strip, n_strip;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic                  r_half, n_half;
    logic [INDEX_BITS-1:0] r_base, n_base;

    // Output register and skid register.
    logic                  r_m_valid;
    logic [INDEX_BITS-1:0] r_m_index;
    logic                  r_m_restart;
    logic                  r_m_last;
    logic                  r_sk_valid;
    logic [INDEX_BITS-1:0] r_sk_index;
    logic                  r_sk_restart;
    logic                  r_sk_last;

    // Result of the current request.
    logic [INDEX_BITS-1:0] c_index;
    logic                  c_restart;
    logic                  c_last;

    logic in_fire;
    logic out_fire;

    // Working values of the index logic.
    logic                  rewind;
    logic [COUNT_BITS-1:0] slices;
    logic [COUNT_BITS-1:0] stacks;
    logic [COUNT_BITS-1:0] e_strip;
    logic [POS_BITS-1:0]   e_pos;
    logic                  e_half;
    logic [INDEX_BITS-1:0] e_base;
    logic                  final_strip;
    logic [COUNT_BITS-1:0] pair_pos;
    logic [COUNT_BITS-1:0] slice_sel;
    logic [SUM_BITS-1:0]   upper_sum;
    logic [SUM_BITS-1:0]   lower_sum;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_sk_valid;
    assign in_fire     = i_s_tvalid && o_s_tready;
    assign out_fire    = r_m_valid && i_m_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_DATA_BITS'(r_m_index);
    assign o_m_tuser  = r_m_restart;
    assign o_m_tlast  = r_m_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_count   <= COUNT_BITS'(dsig_pkg::SLICE_COUNT_RESET);
            r_stack_count   <= COUNT_BITS'(dsig_pkg::STACK_COUNT_RESET);
            r_reverse       <= 1'b0;
            r_restart_value <= INDEX_BITS'(dsig_pkg::RESTART_VALUE_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dsig_pkg::REG_SLICE_COUNT:     r_slice_count   <= COUNT_BITS'(i_cfg_data);
                dsig_pkg::REG_STACK_COUNT:     r_stack_count   <= COUNT_BITS'(i_cfg_data);
                dsig_pkg::REG_REVERSE_WINDING: r_reverse       <= i_cfg_data[0];
                dsig_pkg::REG_RESTART_VALUE:   r_restart_value <= INDEX_BITS'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Index logic: the entry for the current state and the state that follows.
    always_comb begin
        rewind = i_s_tdata[0];
        slices = (r_slice_count == '0) ? COUNT_BITS'(1) : r_slice_count;
        stacks = (r_stack_count < COUNT_BITS'(2)) ? COUNT_BITS'(2) : r_stack_count;

        e_strip = rewind ? '0 : r_strip;
        e_pos   = rewind ? '0 : r_pos;
        e_half  = rewind ? 1'b0 : r_half;
        e_base  = rewind ? INDEX_BITS'(1) : r_base;

        // A strip number past the end, left by a config change, counts as final.
        final_strip = e_strip >= (stacks - COUNT_BITS'(2));

        // The closing pair repeats pair zero.
        pair_pos  = (e_pos == {1'b0, slices}) ? '0 : e_pos[COUNT_BITS-1:0];
        slice_sel = r_reverse ? (slices - COUNT_BITS'(1) - pair_pos) : pair_pos;

        lower_sum = SUM_BITS'(e_base) + SUM_BITS'(slice_sel);
        upper_sum = lower_sum + SUM_BITS'(slices);

        n_strip = e_strip;
        n_pos   = e_pos;
        n_half  = e_half;
        n_base  = e_base;

        if (e_pos > {1'b0, slices}) begin
            c_index   = r_restart_value;
            c_restart = 1'b1;
            c_last    = final_strip;
            if (final_strip) begin
                n_strip = '0;
                n_pos   = '0;
                n_half  = 1'b0;
                n_base  = INDEX_BITS'(1);
            end else begin
                if (e_strip != '0) begin
                    n_base = INDEX_BITS'(SUM_BITS'(e_base) + SUM_BITS'(slices));
                end
                n_strip = e_strip + COUNT_BITS'(1);
                n_pos   = '0;
                n_half  = 1'b0;
            end
        end else begin
            c_restart = 1'b0;
            c_last    = 1'b0;
            if (e_strip == '0) begin
                // Fan around the apex: ring vertex, then apex.
                c_index = e_half ? '0 : INDEX_BITS'(lower_sum);
            end else begin
                // Upper ring vertex, then the matching lower ring vertex.
                c_index = e_half ? INDEX_BITS'(lower_sum) : INDEX_BITS'(upper_sum);
            end
            if (e_half) begin
                n_half = 1'b0;
                n_pos  = e_pos + POS_BITS'(1);
            end else begin
                n_half = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip <= '0;
            r_pos   <= '0;
            r_half  <= 1'b0;
            r_base  <= INDEX_BITS'(1);
        end else if (in_fire) begin
            r_strip <= n_strip;
            r_pos   <= n_pos;
            r_half  <= n_half;
            r_base  <= n_base;
        end
    end

    // Output register with a skid register behind it. The skid register fills
    // only when a result arrives while the output register is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (r_sk_valid) begin
            if (out_fire) begin
                r_m_valid  <= 1'b1;
                r_sk_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_m_valid || out_fire) begin
                r_m_valid <= 1'b1;
            end else begin
                r_sk_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_valid) begin
            if (out_fire) begin
                r_m_index   <= r_sk_index;
                r_m_restart <= r_sk_restart;
                r_m_last    <= r_sk_last;
            end
        end else if (in_fire) begin
            if (!r_m_valid || out_fire) begin
                r_m_index   <= c_index;
                r_m_restart <= c_restart;
                r_m_last    <= c_last;
            end else begin
                r_sk_index   <= c_index;
                r_sk_restart <= c_restart;
                r_sk_last    <= c_last;
            end
        end
    end

    // A filled skid register always sits behind a filled output register.
    `DSIG_ASSERT_SAME(a_skid_behind_output, i_clk, i_rst_n, r_sk_valid, r_m_valid)

    // A held skid entry is not dropped while the output stays stalled.
    `DSIG_ASSERT_NEXT(a_skid_held, i_clk, i_rst_n, r_sk_valid && !out_fire, r_sk_valid)

    // The end of the list is always a restart entry.
    `DSIG_ASSERT_SAME(a_last_is_restart, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, o_m_tuser)

    // A rewind request always starts the fan strip again.
    `DSIG_ASSERT_NEXT(a_rewind_restarts, i_clk, i_rst_n, in_fire && rewind, r_strip == '0)

endmodule
